>>> src/hsg_pkg.sv
// Shared types and constants of the hex20 shape gradient core.
// Used by hsg_divider and hex20_shape_gradient_core; depends on nothing else.
package hsg_pkg;

  // Signed width of the gradient numerator (4 * sum d*adj).
  localparam int unsigned NumW = 104;
  // Signed width of the Jacobian determinant.
  localparam int unsigned DetW = 98;
  // Signed width of a reference derivative, Q30.
  localparam int unsigned DerW = 37;
  // Signed width of the derivative multiplier operands.
  localparam int unsigned OpW = 36;
  // Nodes of the serendipity hexahedron.
  localparam int unsigned NodeCount = 20;
  localparam logic [4:0] LastNode = 5'(NodeCount - 1);

  // Control information that travels alongside each node.
  typedef struct packed {
    logic [4:0] node;
    logic       last;
    logic       sing;
  } node_tag_t;

  // Node signs per axis, bit 0 xi, bit 1 eta, bit 2 zeta.
  // zero marks the edge axis of a mid-edge node, neg a minus sign.
  typedef struct packed {
    logic [2:0] zero;
    logic [2:0] neg;
  } node_sign_t;

  function automatic node_sign_t node_sign(input logic [4:0] nd);
    node_sign_t s;
    case (nd)
      5'd0:    s = '{zero: 3'b000, neg: 3'b111};
      5'd1:    s = '{zero: 3'b000, neg: 3'b110};
      5'd2:    s = '{zero: 3'b000, neg: 3'b100};
      5'd3:    s = '{zero: 3'b000, neg: 3'b101};
      5'd4:    s = '{zero: 3'b000, neg: 3'b011};
      5'd5:    s = '{zero: 3'b000, neg: 3'b010};
      5'd6:    s = '{zero: 3'b000, neg: 3'b000};
      5'd7:    s = '{zero: 3'b000, neg: 3'b001};
      5'd8:    s = '{zero: 3'b001, neg: 3'b110};
      5'd9:    s = '{zero: 3'b010, neg: 3'b100};
      5'd10:   s = '{zero: 3'b001, neg: 3'b100};
      5'd11:   s = '{zero: 3'b010, neg: 3'b101};
      5'd12:   s = '{zero: 3'b100, neg: 3'b011};
      5'd13:   s = '{zero: 3'b100, neg: 3'b010};
      5'd14:   s = '{zero: 3'b100, neg: 3'b000};
      5'd15:   s = '{zero: 3'b100, neg: 3'b001};
      5'd16:   s = '{zero: 3'b001, neg: 3'b010};
      5'd17:   s = '{zero: 3'b010, neg: 3'b000};
      5'd18:   s = '{zero: 3'b001, neg: 3'b000};
      5'd19:   s = '{zero: 3'b010, neg: 3'b001};
      default: s = '{zero: 3'b000, neg: 3'b000};
    endcase
    return s;
  endfunction

endpackage

>>> src/hsg_divider.sv
// Pipelined restoring divider for the three gradient lanes, with saturation.
// Depends on hsg_pkg for widths and the node tag type.
module hsg_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [2:0][hsg_pkg::NumW-2:0]        num_i,
  input  logic [hsg_pkg::DetW-2:0]             den_i,
  input  logic [2:0]                           neg_i,
  input  hsg_pkg::node_tag_t                   tag_i,
  output logic                                 valid_o,
  output logic [2:0][31:0]                     grad_o,
  output hsg_pkg::node_tag_t                   tag_o
);
  import hsg_pkg::*;

  localparam int unsigned AW = NumW - 1;
  localparam int unsigned BW = DetW - 1;
  localparam int unsigned QW = 32;
  localparam int unsigned CW = BW + QW;
  localparam logic [31:0] PosMax = 32'h7FFF_FFFF;
  localparam logic [31:0] NegMax = 32'h8000_0000;

  logic [AW-1:0]  rem_q [QW+1][3];
  logic [QW-1:0]  quo_q [QW+1][3];
  logic [2:0]     ovf_q [QW+1];
  logic [2:0]     neg_q [QW+1];
  logic [BW-1:0]  den_q [QW+1];
  node_tag_t      tag_q [QW+1];
  logic [QW:0]    vld_q;

  // Stage 0 flags a quotient of 2^32 or more; stage s settles quotient bit QW-s.
  for (genvar s = 0; s <= QW; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        for (int l = 0; l < 3; l++) begin
          ovf_q[0][l] <= CW'(num_i[l]) >= (CW'(den_i) << QW);
          rem_q[0][l] <= num_i[l];
          quo_q[0][l] <= '0;
        end
        neg_q[0] <= neg_i;
        den_q[0] <= den_i;
        tag_q[0] <= tag_i;
      end
    end else begin : g_bit
      localparam int unsigned Bit = QW - s;
      logic [CW-1:0] sub [3];
      logic [2:0]    fit;
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          sub[l] = CW'(den_q[s-1]) << Bit;
          fit[l] = CW'(rem_q[s-1][l]) >= sub[l];
        end
      end
      always_ff @(posedge clk_i) begin
        for (int l = 0; l < 3; l++) begin
          rem_q[s][l] <= fit[l] ? rem_q[s-1][l] - sub[l][AW-1:0] : rem_q[s-1][l];
          quo_q[s][l] <= quo_q[s-1][l] | (fit[l] ? (QW'(1) << Bit) : '0);
        end
        ovf_q[s] <= ovf_q[s-1];
        neg_q[s] <= neg_q[s-1];
        den_q[s] <= den_q[s-1];
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      vld_q   <= {vld_q[QW-1:0], valid_i};
      valid_o <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      if (tag_q[QW].sing) begin
        grad_o[l] <= '0;
      end else if (!neg_q[QW][l]) begin
        grad_o[l] <= (ovf_q[QW][l] || quo_q[QW][l][QW-1]) ? PosMax : quo_q[QW][l];
      end else begin
        grad_o[l] <= (ovf_q[QW][l] || quo_q[QW][l] > NegMax) ? NegMax : -quo_q[QW][l];
      end
    end
    tag_o <= tag_q[QW];
  end

endmodule

>>> src/hex20_shape_gradient_core.sv
// Top level of the hex20 shape gradient core: node sequencing, derivatives,
// adjugate, determinant and dot products. Depends on hsg_pkg and hsg_divider.
//
// Usage. An integration point (the nine Jacobian entries in Q16.16 and the
// reference coordinates xi, eta and zeta in Q2.30) is transferred at a rising
// edge with start high and busy low. The core then feeds the twenty nodes of
// that point, one per cycle, into a single pipeline. The busy output stays
// high until the sequencer issues node 19, and the next point can be
// transferred while node 19 is issued: one result every cycle while points keep coming.
// The rate is set by the node sequencer, which issues one node per clock.
// Each node passes through eight arithmetic stages (derivative operands and
// cofactors, adjugate, derivative products, determinant and numerator sums,
// magnitudes) and then a 33-stage restoring divider, whose first stage flags
// an oversized quotient and whose other 32 settle one quotient bit each for
// all three gradients, followed by a saturation register.
// The result for node 0 is shown on the result ports after the arithmetic
// stages, the divider and the saturation register, marked by res_strobe_o,
// and nodes 1 to 19 follow without gaps; last_node_o marks node 19.
// The receiver cannot stall, so each result is valid for exactly one cycle.
// A zero determinant raises singular_o and zeroes all three gradients.
// Reset clears the sequencer and every pipeline valid bit; no other state
// is kept between points.
module hex20_shape_gradient_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] jac_00_i,
  input  logic signed [31:0] jac_01_i,
  input  logic signed [31:0] jac_02_i,
  input  logic signed [31:0] jac_10_i,
  input  logic signed [31:0] jac_11_i,
  input  logic signed [31:0] jac_12_i,
  input  logic signed [31:0] jac_20_i,
  input  logic signed [31:0] jac_21_i,
  input  logic signed [31:0] jac_22_i,
  input  logic signed [31:0] xi_coord_i,
  input  logic signed [31:0] eta_coord_i,
  input  logic signed [31:0] zeta_coord_i,
  output logic               res_strobe_o,
  output logic [4:0]         node_index_o,
  output logic signed [31:0] grad_x_o,
  output logic signed [31:0] grad_y_o,
  output logic signed [31:0] grad_z_o,
  output logic               last_node_o,
  output logic               singular_o
);
  import hsg_pkg::*;

  // Which floor shift the second derivative product takes.
  typedef enum logic [1:0] {Sh31, Sh32, Sh33} shift_e;

  localparam logic signed [OpW-1:0] OneQ30 = {{(OpW-31){1'b0}}, 1'b1, 30'd0};
  localparam int unsigned PW  = 2 * OpW;
  localparam int unsigned DpW = DerW + 33;

  logic                accept;
  logic                running_q;
  logic [4:0]          node_q;
  logic signed [31:0]  jac_in  [3][3];
  logic signed [31:0]  crd_in  [3];
  logic signed [31:0]  jac_q   [3][3];
  logic signed [31:0]  crd_q   [3];

  assign accept = start && !busy;
  assign busy   = running_q && (node_q != LastNode);

  assign jac_in[0][0] = jac_00_i;
  assign jac_in[0][1] = jac_01_i;
  assign jac_in[0][2] = jac_02_i;
  assign jac_in[1][0] = jac_10_i;
  assign jac_in[1][1] = jac_11_i;
  assign jac_in[1][2] = jac_12_i;
  assign jac_in[2][0] = jac_20_i;
  assign jac_in[2][1] = jac_21_i;
  assign jac_in[2][2] = jac_22_i;
  assign crd_in[0]    = xi_coord_i;
  assign crd_in[1]    = eta_coord_i;
  assign crd_in[2]    = zeta_coord_i;

  // Node sequencer: a transfer restarts the count, the point is held while
  // its twenty nodes are issued.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      node_q    <= '0;
    end else if (accept) begin
      running_q <= 1'b1;
      node_q    <= '0;
    end else if (running_q) begin
      if (node_q == LastNode) begin
        running_q <= 1'b0;
      end
      node_q <= node_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      jac_q <= jac_in;
      crd_q <= crd_in;
    end
  end

  // Valid bits and node numbers of stages 2 to 9.
  logic [7:0] vld_q;
  logic [4:0] nd_q [8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[6:0], running_q};
    end
  end

  always_ff @(posedge clk_i) begin
    nd_q[0] <= node_q;
    for (int i = 1; i < 8; i++) begin
      nd_q[i] <= nd_q[i-1];
    end
  end

  // Stage 1: operand selection for the derivative products. A corner node
  // takes P_m*P_n then the linear term; along the edge axis of a mid-edge
  // node it is P_m*P_n then the coordinate; across the edge it is the
  // quadratic bubble 1-c^2 times the P of the remaining axis.
  node_sign_t              sg;
  logic signed [OpW-1:0]   cx  [3];
  logic signed [OpW-1:0]   sc  [3];
  logic signed [OpW-1:0]   pv  [3];
  logic signed [OpW-1:0]   lin;

  assign sg = node_sign(node_q);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cx[k] = OpW'(crd_q[k]);
      sc[k] = sg.neg[k] ? -cx[k] : cx[k];
      pv[k] = OneQ30 + sc[k];
    end
    lin = sc[0] + sc[1] + sc[2] - OneQ30;
  end

  logic signed [OpW-1:0] x2_q [3];
  logic signed [OpW-1:0] y2_q [3];
  logic signed [OpW-1:0] z2_q [3];
  shift_e                sh2_q [3];
  logic [2:0]            useq2_q;
  logic [2:0]            neg2_q;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    localparam int M = (k + 1) % 3;
    localparam int N = (k + 2) % 3;
    logic signed [OpW-1:0] xs, ys, zs;
    shift_e                shs;
    logic                  uq, ng;
    always_comb begin
      if (sg.zero == 3'b000) begin
        xs = pv[M];
        ys = pv[N];
        zs = lin + sc[k];
        shs = Sh33;
        uq = 1'b0;
        ng = sg.neg[k];
      end else if (sg.zero[k]) begin
        xs = pv[M];
        ys = pv[N];
        zs = cx[k];
        shs = Sh31;
        uq = 1'b0;
        ng = 1'b1;
      end else begin
        xs = sg.zero[M] ? cx[M] : cx[N];
        ys = xs;
        zs = sg.zero[M] ? pv[N] : pv[M];
        shs = Sh32;
        uq = 1'b1;
        ng = sg.neg[k];
      end
    end
    always_ff @(posedge clk_i) begin
      x2_q[k]    <= xs;
      y2_q[k]    <= ys;
      z2_q[k]    <= zs;
      sh2_q[k]   <= shs;
      useq2_q[k] <= uq;
      neg2_q[k]  <= ng;
    end
  end

  // Stage 1 also forms the cofactor products of the adjugate.
  logic signed [63:0] adjp2_q [3][3][2];
  logic signed [31:0] j0_2_q  [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        adjp2_q[i][k][0] <= jac_q[(k+1)%3][(i+1)%3] * jac_q[(k+2)%3][(i+2)%3];
        adjp2_q[i][k][1] <= jac_q[(k+1)%3][(i+2)%3] * jac_q[(k+2)%3][(i+1)%3];
      end
      j0_2_q[i] <= jac_q[0][i];
    end
  end

  // Stage 2: adjugate entries and the first derivative product.
  logic signed [64:0]    adj3_q [3][3];
  logic signed [31:0]    j0_3_q [3];
  logic signed [PW-1:0]  prod1  [3];
  logic signed [OpW-1:0] r3_q   [3];
  logic signed [OpW-1:0] z3_q   [3];
  shift_e                sh3_q  [3];
  logic [2:0]            useq3_q;
  logic [2:0]            neg3_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod1[k] = x2_q[k] * y2_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        adj3_q[i][k] <= 65'(adjp2_q[i][k][0]) - 65'(adjp2_q[i][k][1]);
      end
      r3_q[i] <= prod1[i][OpW+29:30];
    end
    j0_3_q  <= j0_2_q;
    z3_q    <= z2_q;
    sh3_q   <= sh2_q;
    useq3_q <= useq2_q;
    neg3_q  <= neg2_q;
  end

  // Stage 3: determinant partial products and the second derivative product.
  logic signed [OpW-1:0]  wv    [3];
  logic signed [PW-1:0]   prod2 [3];
  logic signed [DerW-1:0] e4_q  [3];
  logic [2:0]             neg4_q;
  logic signed [64:0]     dp4_q [3][2];
  logic signed [64:0]     adj4_q [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wv[k]    = useq3_q[k] ? OneQ30 - r3_q[k] : r3_q[k];
      prod2[k] = wv[k] * z3_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      case (sh3_q[k])
        Sh31:    e4_q[k] <= prod2[k][DerW+30:31];
        Sh32:    e4_q[k] <= prod2[k][DerW+31:32];
        Sh33:    e4_q[k] <= prod2[k][DerW+32:33];
        default: e4_q[k] <= prod2[k][DerW+32:33];
      endcase
      dp4_q[k][0] <= j0_3_q[k] * $signed({1'b0, adj3_q[k][0][31:0]});
      dp4_q[k][1] <= j0_3_q[k] * $signed(adj3_q[k][0][64:32]);
    end
    neg4_q <= neg3_q;
    adj4_q <= adj3_q;
  end

  // Stage 4: signed derivatives and recombined determinant terms.
  logic signed [DerW-1:0] d5_q    [3];
  logic signed [DetW-1:0] detk5_q [3];
  logic signed [64:0]     adj5_q  [3][3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      d5_q[k]    <= neg4_q[k] ? -e4_q[k] : e4_q[k];
      detk5_q[k] <= (DetW'(dp4_q[k][1]) <<< 32) + DetW'(dp4_q[k][0]);
    end
    adj5_q <= adj4_q;
  end

  // Stage 5: determinant sum and the dot product partial products.
  logic signed [DetW-1:0] det6_q;
  logic signed [DpW-1:0]  pp6_q [3][3][2];

  always_ff @(posedge clk_i) begin
    det6_q <= detk5_q[0] + detk5_q[1] + detk5_q[2];
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        pp6_q[r][k][0] <= d5_q[k] * $signed({1'b0, adj5_q[r][k][31:0]});
        pp6_q[r][k][1] <= d5_q[k] * $signed(adj5_q[r][k][64:32]);
      end
    end
  end

  // Stage 6: recombined dot product terms.
  logic signed [NumW-1:0] term7_q [3][3];
  logic signed [DetW-1:0] det7_q;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        term7_q[r][k] <= (NumW'(pp6_q[r][k][1]) <<< 32) + NumW'(pp6_q[r][k][0]);
      end
    end
    det7_q <= det6_q;
  end

  // Stage 7: numerators, scaled by four.
  logic signed [NumW-1:0] num8_q [3];
  logic signed [DetW-1:0] det8_q;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      num8_q[r] <= (term7_q[r][0] + term7_q[r][1] + term7_q[r][2]) <<< 2;
    end
    det8_q <= det7_q;
  end

  // Stage 8: magnitudes and quotient signs for the divider.
  logic [2:0][NumW-2:0]  an9_q;
  logic [DetW-2:0]       ad9_q;
  logic [2:0]            neg9_q;
  node_tag_t             tag9_q;
  logic signed [NumW-1:0] nabs [3];
  logic signed [DetW-1:0] dabs;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nabs[r] = num8_q[r][NumW-1] ? -num8_q[r] : num8_q[r];
    end
    dabs = det8_q[DetW-1] ? -det8_q : det8_q;
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      an9_q[r]  <= nabs[r][NumW-2:0];
      neg9_q[r] <= num8_q[r][NumW-1] ^ det8_q[DetW-1];
    end
    ad9_q       <= dabs[DetW-2:0];
    tag9_q.node <= nd_q[6];
    tag9_q.last <= nd_q[6] == LastNode;
    tag9_q.sing <= det8_q == '0;
  end

  logic [2:0][31:0] grad;
  node_tag_t        tag_out;

  hsg_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[7]),
    .num_i   (an9_q),
    .den_i   (ad9_q),
    .neg_i   (neg9_q),
    .tag_i   (tag9_q),
    .valid_o (res_strobe_o),
    .grad_o  (grad),
    .tag_o   (tag_out)
  );

  assign grad_x_o     = $signed(grad[0]);
  assign grad_y_o     = $signed(grad[1]);
  assign grad_z_o     = $signed(grad[2]);
  assign node_index_o = tag_out.node;
  assign last_node_o  = tag_out.last;
  assign singular_o   = tag_out.sing;

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a point transfer");

  a_last_is_node19: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && last_node_o) |-> (node_index_o == LastNode))
    else $error("last_node_o set on a node other than the last");

  a_nodes_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !last_node_o) |=>
      (res_strobe_o && node_index_o == $past(node_index_o) + 5'd1))
    else $error("results of a point are not contiguous");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && singular_o) |->
      (grad_x_o == 32'sd0 && grad_y_o == 32'sd0 && grad_z_o == 32'sd0))
    else $error("singular result carries a nonzero gradient");
`endif

endmodule
